// File: rtl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg: shared types and constants for the periodic task scheduler
// Holds the item structs, command and status codes, table sizing and the
// controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

  // Table sizing (2 to 256 slots)
  localparam int NUM_TASKS = 16;
  localparam int IDX_W     = $clog2(NUM_TASKS);
  localparam int CNT_W     = $clog2(NUM_TASKS + 1);

  // At most this many run results per scan
  localparam int SCAN_CAP  = 16;
  localparam int SCN_W     = $clog2(SCAN_CAP + 1);

  // Command codes
  localparam logic [3:0] CMD_TICK    = 4'd0;
  localparam logic [3:0] CMD_SCAN    = 4'd1;
  localparam logic [3:0] CMD_ADD     = 4'd2;
  localparam logic [3:0] CMD_SUSPEND = 4'd3;
  localparam logic [3:0] CMD_RESUME  = 4'd4;
  localparam logic [3:0] CMD_RESET   = 4'd5;
  localparam logic [3:0] CMD_DELETE  = 4'd6;
  localparam logic [3:0] CMD_SLEEP   = 4'd7;
  localparam logic [3:0] CMD_WAKEUP  = 4'd8;

  // Status codes
  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_INVALID = 2'd1;
  localparam logic [1:0] STS_UNUSED  = 2'd2;
  localparam logic [1:0] STS_FULL    = 2'd3;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [7:0]  task_id;
    logic [31:0] ticks;
  } pts_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       run_valid;
    logic [7:0] run_task;
    logic       last;
  } pts_out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FINISH
  } pts_state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;    // latch the accepted item, rewind the scan
    logic exec;       // apply a slot/tick command and load its result
    logic scan_step;  // evaluate the current slot and advance
    logic finish;     // load the closing scan result
  } pts_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_scan;
    logic out_busy;
    logic emit;
    logic hold_valid;
    logic at_end;
  } pts_stat_t;

endpackage

`default_nettype wire

// File: rtl/pts_ctrl.sv
// ----------------------------------------------------------------------------
// pts_ctrl: sequencing state machine
// Accepts one item at a time, runs tick and slot commands or a slot-by-slot
// scan, and waits on the result register when it is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_ctrl
  import pts_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        cmd_valid,
  output logic       cmd_ready,
  input  pts_stat_t  stat,
  output pts_cmd_t   ctl
);

  pts_state_t state;
  pts_state_t state_next;
  logic       scan_stall;

  // Hold the scan when a second due slot needs the busy result register
  assign scan_stall = stat.emit && stat.hold_valid && stat.out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (stat.is_scan) state_next = S_SCAN;
        else if (!stat.out_busy) state_next = S_IDLE;
      end
      S_SCAN: begin
        if (!scan_stall && stat.at_end) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!stat.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready     = 1'b0;
    ctl           = '0;
    case (state)
      S_IDLE: begin
        cmd_ready   = 1'b1;
        ctl.capture = cmd_valid;
      end
      S_EXEC: begin
        ctl.exec = !stat.is_scan && !stat.out_busy;
      end
      S_SCAN: begin
        ctl.scan_step = !scan_stall;
      end
      S_FINISH: begin
        ctl.finish = !stat.out_busy;
      end
      default: begin
        cmd_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/pts_datapath.sv
// ----------------------------------------------------------------------------
// pts_datapath: task table, tick counter and result register
// Slot flags live in flops; period, last run and sleep length live in
// memories with one write and one registered read port each.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_datapath
  import pts_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  pts_in_t    cmd_data,
  input  pts_cmd_t   ctl,
  output pts_stat_t  stat,
  output logic       res_valid,
  input  wire        res_ready,
  output pts_out_t   res_data
);

  // Captured item
  pts_in_t            cur;

  // Slot state
  logic [NUM_TASKS-1:0] used;
  logic [NUM_TASKS-1:0] running;
  logic [NUM_TASKS-1:0] sleeping;
  logic [31:0]          tick_now;
  logic [CNT_W-1:0]     used_count;

  logic [31:0] period_mem [NUM_TASKS];
  logic [31:0] last_mem   [NUM_TASKS];
  logic [31:0] sleep_mem  [NUM_TASKS];
  logic [31:0] period_rd;
  logic [31:0] last_rd;
  logic [31:0] sleep_rd;

  // Scan state
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] rd_addr;
  logic [SCN_W-1:0] n_emit;
  logic             hold_valid;
  logic [IDX_W-1:0] hold_task;

  // Command decode
  logic [IDX_W-1:0] sid;
  logic             bad_id;
  logic [1:0]       exec_status;
  logic             exec_ok;

  // Scan evaluation
  logic        active;
  logic [31:0] elapsed;
  logic        wake;
  logic        emit;
  logic        at_end;

  // Memory write ports
  logic             per_we;
  logic [IDX_W-1:0] per_wa;
  logic [31:0]      per_wd;
  logic             lst_we;
  logic [IDX_W-1:0] lst_wa;
  logic [31:0]      lst_wd;
  logic             slp_we;
  logic [IDX_W-1:0] slp_wa;
  logic [31:0]      slp_wd;

  // Result register
  logic     out_busy;
  logic     out_load;
  pts_out_t out_next;

  assign sid    = cur.task_id[IDX_W-1:0];
  assign bad_id = {1'b0, cur.task_id} >= 9'(NUM_TASKS);

  always_comb begin
    exec_status = STS_OK;
    case (cur.cmd)
      CMD_TICK: exec_status = STS_OK;
      CMD_ADD: begin
        if (bad_id) exec_status = STS_INVALID;
        else if (used_count == CNT_W'(NUM_TASKS)) exec_status = STS_FULL;
      end
      CMD_DELETE: begin
        if (bad_id) exec_status = STS_INVALID;
      end
      CMD_SLEEP: begin
        if (bad_id || cur.ticks == 32'd0) exec_status = STS_INVALID;
        else if (!used[sid]) exec_status = STS_UNUSED;
      end
      CMD_SUSPEND, CMD_RESUME, CMD_RESET, CMD_WAKEUP: begin
        if (bad_id) exec_status = STS_INVALID;
        else if (!used[sid]) exec_status = STS_UNUSED;
      end
      default: exec_status = STS_INVALID;
    endcase
  end

  assign exec_ok = ctl.exec && (exec_status == STS_OK);

  // Scan: evaluate slot idx against registered table data
  assign active  = used[idx] && running[idx];
  assign elapsed = tick_now - last_rd;
  assign wake    = active && sleeping[idx] && (elapsed >= sleep_rd);
  assign emit    = active && (!sleeping[idx] || wake) && (elapsed >= period_rd)
                   && (n_emit < SCN_W'(SCAN_CAP));
  assign at_end  = idx == IDX_W'(NUM_TASKS - 1);
  assign rd_addr = (ctl.scan_step && !at_end) ? idx + 1'b1 : idx;

  // Memory write selection
  always_comb begin
    per_we = 1'b0;
    per_wa = sid;
    per_wd = cur.ticks;
    lst_we = 1'b0;
    lst_wa = sid;
    lst_wd = tick_now;
    slp_we = 1'b0;
    slp_wa = sid;
    slp_wd = 32'd0;
    if (exec_ok) begin
      case (cur.cmd)
        CMD_ADD: begin
          per_we = 1'b1;
          lst_we = 1'b1;
          lst_wd = 32'd0;
        end
        CMD_DELETE: begin
          per_we = 1'b1;
          per_wd = 32'd0;
          lst_we = 1'b1;
          lst_wd = 32'd0;
          slp_we = 1'b1;
        end
        CMD_SLEEP: begin
          lst_we = 1'b1;
          slp_we = 1'b1;
          slp_wd = cur.ticks;
        end
        CMD_RESET: begin
          lst_we = 1'b1;
          slp_we = 1'b1;
        end
        CMD_WAKEUP: slp_we = 1'b1;
        default: per_we = 1'b0;
      endcase
    end else if (ctl.scan_step) begin
      lst_we = emit;
      lst_wa = idx;
      slp_we = wake;
      slp_wa = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (per_we) period_mem[per_wa] <= per_wd;
    if (lst_we) last_mem[lst_wa]   <= lst_wd;
    if (slp_we) sleep_mem[slp_wa]  <= slp_wd;
    period_rd <= period_mem[rd_addr];
    last_rd   <= last_mem[rd_addr];
    sleep_rd  <= sleep_mem[rd_addr];
  end

  // Slot flags, tick counter, occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      used       <= '0;
      running    <= '0;
      sleeping   <= '0;
      tick_now   <= '0;
      used_count <= '0;
    end else if (ctl.exec) begin
      if (cur.cmd == CMD_TICK) tick_now <= tick_now + 32'd1;
      if (exec_ok) begin
        case (cur.cmd)
          CMD_ADD: begin
            if (!used[sid]) used_count <= used_count + 1'b1;
            used[sid]     <= 1'b1;
            running[sid]  <= 1'b1;
            sleeping[sid] <= 1'b0;
          end
          CMD_DELETE: begin
            if (used[sid]) used_count <= used_count - 1'b1;
            used[sid]     <= 1'b0;
            running[sid]  <= 1'b0;
            sleeping[sid] <= 1'b0;
          end
          CMD_SLEEP:   sleeping[sid] <= 1'b1;
          CMD_SUSPEND: running[sid]  <= 1'b0;
          CMD_RESUME:  running[sid]  <= 1'b1;
          CMD_RESET:   running[sid]  <= 1'b0;
          CMD_WAKEUP:  sleeping[sid] <= 1'b0;
          default:     running[sid]  <= running[sid];
        endcase
      end
    end else if (ctl.scan_step && wake) begin
      sleeping[idx] <= 1'b0;
    end
  end

  // Item capture and scan progress
  always_ff @(posedge clk) begin
    if (ctl.capture) cur <= cmd_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      n_emit     <= '0;
      hold_valid <= 1'b0;
    end else if (ctl.capture) begin
      idx        <= '0;
      n_emit     <= '0;
      hold_valid <= 1'b0;
    end else if (ctl.scan_step) begin
      if (!at_end) idx <= idx + 1'b1;
      if (emit) begin
        n_emit     <= n_emit + 1'b1;
        hold_valid <= 1'b1;
      end
    end else if (ctl.finish) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.scan_step && emit) hold_task <= idx;
  end

  // Result register: one due slot is held back until the next one or the
  // end of the scan shows whether it is the final result
  assign out_busy = res_valid && !res_ready;

  always_comb begin
    out_load = 1'b0;
    out_next = '0;
    if (ctl.exec) begin
      out_load        = 1'b1;
      out_next.status = exec_status;
      out_next.last   = 1'b1;
    end else if (ctl.scan_step && emit && hold_valid) begin
      out_load           = 1'b1;
      out_next.run_valid = 1'b1;
      out_next.run_task  = 8'(hold_task);
    end else if (ctl.finish) begin
      out_load           = 1'b1;
      out_next.run_valid = hold_valid;
      out_next.run_task  = hold_valid ? 8'(hold_task) : 8'd0;
      out_next.last      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) res_data <= out_next;
  end

  assign stat.is_scan    = cur.cmd == CMD_SCAN;
  assign stat.out_busy   = out_busy;
  assign stat.emit       = emit;
  assign stat.hold_valid = hold_valid;
  assign stat.at_end     = at_end;

endmodule

`default_nettype wire

// File: rtl/periodic_task_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_task_scheduler: cooperative periodic task table
// Tick, slot edit and scan commands over a table of NUM_TASKS slots.
// ----------------------------------------------------------------------------
//
//   channel | signals                         | direction | payload
//   --------+---------------------------------+-----------+-----------
//   cmd     | cmd_valid, cmd_ready, cmd_data  | in        | pts_in_t
//   res     | res_valid, res_ready, res_data  | out       | pts_out_t
//
// A tick or slot command is accepted, then executed while the result register
// is loaded. A scan is accepted, then primes the table read port, walks the
// NUM_TASKS slots in order and ends with a closing step.
// The per-slot walk is set by the single registered read port of each table
// memory. A busy result register holds the controller in place; a new item
// is taken once the previous one has loaded its final result.
// Reset (rst, synchronous) clears all slot flags, the tick count and the
// occupancy count; table memories need no clearing, a slot's fields are
// always written before they are used.
//
`default_nettype none

module periodic_task_scheduler
  import pts_pkg::*;
(
  input  wire       clk,
  input  wire       rst,
  input  wire       cmd_valid,
  output logic      cmd_ready,
  input  pts_in_t   cmd_data,
  output logic      res_valid,
  input  wire       res_ready,
  output pts_out_t  res_data
);

  // Command and status between the sequencer and the table
  pts_cmd_t  ctl;
  pts_stat_t stat;

  // Sequence commands and scans, one item at a time
  pts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  // Hold the task table, tick count and result register
  pts_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd_data  (cmd_data),
    .ctl       (ctl),
    .stat      (stat),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

endmodule

`default_nettype wire

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for periodic_task_scheduler
// Drives tick, scan and slot-edit command items into the scheduler under
// random idling on both channels, predicts every result item with an
// independent model of the task table, and compares results in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import pts_pkg::*;

  localparam int HOLD_CYCLES = 400;   // long receiver hold-off to fill the block
  localparam int DRAIN_CYCLES = 2 * NUM_TASKS + 8;
  localparam int RAND_A = 115;
  localparam int RAND_B = 115;
  localparam int RAND_C = 115;

  // --------------------------------------------------------------------------
  // Scoreboard: table model plus the queue of result items still owed
  // --------------------------------------------------------------------------
  class sched_sb;
    logic        used     [NUM_TASKS];
    logic        running  [NUM_TASKS];
    logic        sleeping [NUM_TASKS];
    logic [31:0] period   [NUM_TASKS];
    logic [31:0] last_run [NUM_TASKS];
    logic [31:0] sleep_len[NUM_TASKS];
    logic [31:0] now;
    int unsigned n_used;

    pts_out_t    owed_q[$];
    int          errors;
    int          cmds_seen;
    int          scans_seen;
    int          runs_seen;
    int          sts_cnt[4];

    function new();
      for (int i = 0; i < NUM_TASKS; i++) begin
        used[i]      = 1'b0;
        running[i]   = 1'b0;
        sleeping[i]  = 1'b0;
        period[i]    = '0;
        last_run[i]  = '0;
        sleep_len[i] = '0;
      end
      now = '0;
      n_used = 0;
      errors = 0;
      cmds_seen = 0;
      scans_seen = 0;
      runs_seen = 0;
      for (int k = 0; k < 4; k++) sts_cnt[k] = 0;
    endfunction

    function void owe(logic [1:0] st, logic rv, logic [7:0] slot, logic lst);
      pts_out_t e;
      e.status    = st;
      e.run_valid = rv;
      e.run_task  = slot;
      e.last      = lst;
      owed_q.push_back(e);
    endfunction

    // Apply one slot-edit command and return its status
    function logic [1:0] edit_slot(pts_in_t it);
      int id;
      id = it.task_id;
      if (it.cmd > CMD_WAKEUP) return STS_INVALID;
      if (id >= NUM_TASKS) return STS_INVALID;
      case (it.cmd)
        CMD_ADD: begin
          if (n_used >= NUM_TASKS) return STS_FULL;
          if (!used[id]) n_used++;
          period[id]   = it.ticks;
          last_run[id] = '0;
          running[id]  = 1'b1;
          used[id]     = 1'b1;
          sleeping[id] = 1'b0;
          return STS_OK;
        end
        CMD_DELETE: begin
          if (used[id] && n_used > 0) n_used--;
          used[id]      = 1'b0;
          running[id]   = 1'b0;
          sleeping[id]  = 1'b0;
          period[id]    = '0;
          last_run[id]  = '0;
          sleep_len[id] = '0;
          return STS_OK;
        end
        CMD_SLEEP: begin
          // zero length is rejected before the in-use check
          if (it.ticks == '0) return STS_INVALID;
          if (!used[id]) return STS_UNUSED;
          sleeping[id]  = 1'b1;
          sleep_len[id] = it.ticks;
          last_run[id]  = now;
          return STS_OK;
        end
        default: ;
      endcase
      if (!used[id]) return STS_UNUSED;
      case (it.cmd)
        CMD_SUSPEND: running[id] = 1'b0;
        CMD_RESUME:  running[id] = 1'b1;
        CMD_RESET: begin
          last_run[id]  = now;
          running[id]   = 1'b0;
          sleep_len[id] = '0;
        end
        default: begin
          sleeping[id]  = 1'b0;
          sleep_len[id] = '0;
        end
      endcase
      return STS_OK;
    endfunction

    // Note an accepted command item and queue the result items it owes
    function void note_cmd(pts_in_t it);
      int          hits[$];
      logic [31:0] elapsed;
      logic [1:0]  st;
      cmds_seen++;
      if (it.cmd == CMD_TICK) begin
        now = now + 32'd1;
        owe(STS_OK, 1'b0, 8'd0, 1'b1);
        sts_cnt[STS_OK]++;
      end else if (it.cmd == CMD_SCAN) begin
        scans_seen++;
        for (int i = 0; i < NUM_TASKS; i++) begin
          if (!used[i] || !running[i]) continue;
          elapsed = now - last_run[i];
          if (sleeping[i] && elapsed >= sleep_len[i]) begin
            sleeping[i]  = 1'b0;
            sleep_len[i] = '0;
          end
          if (sleeping[i]) continue;
          if (elapsed >= period[i] && hits.size() < SCAN_CAP) begin
            hits.push_back(i);
            last_run[i] = now;
          end
        end
        if (hits.size() == 0) begin
          owe(STS_OK, 1'b0, 8'd0, 1'b1);
        end else begin
          for (int k = 0; k < hits.size(); k++)
            owe(STS_OK, 1'b1, 8'(hits[k]), k == hits.size() - 1);
          runs_seen += hits.size();
        end
      end else begin
        st = edit_slot(it);
        owe(st, 1'b0, 8'd0, 1'b1);
        sts_cnt[st]++;
      end
    endfunction

    // Check one accepted result item against the oldest owed one
    function void check_res(pts_out_t got);
      pts_out_t e;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result item %h", $time, got);
        errors++;
        return;
      end
      e = owed_q.pop_front();
      if (got.status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
        errors++;
      end
      if (got.run_valid !== e.run_valid) begin
        $display("%0t: run_valid expected %0d actual %0d", $time, e.run_valid,
                 got.run_valid);
        errors++;
      end
      if (got.run_task !== e.run_task) begin
        $display("%0t: run_task expected %0d actual %0d", $time, e.run_task,
                 got.run_task);
        errors++;
      end
      if (got.last !== e.last) begin
        $display("%0t: last expected %0d actual %0d", $time, e.last, got.last);
        errors++;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block under test
  // --------------------------------------------------------------------------
  logic     clk = 1'b0;
  logic     rst;
  logic     cmd_valid;
  logic     cmd_ready;
  pts_in_t  cmd_data;
  logic     res_valid;
  logic     res_ready;
  pts_out_t res_data;

  sched_sb     sb;
  int unsigned snd_idle;    // percent of cycles the sender idles
  int unsigned rcv_idle;    // percent of cycles the receiver stalls
  int          hold_req;    // bump to request a long receiver hold-off
  int          hold_seen;
  int          hold_left;

  periodic_task_scheduler i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_data  (cmd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  always #1 clk = ~clk;

  // Sample both handshakes with the values settled before the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && cmd_ready) sb.note_cmd(cmd_data);
      if (res_valid && res_ready) sb.check_res(res_data);
    end
  end

  // Receiver: random stalls, plus a long hold-off counted here on request
  initial begin
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        res_ready <= 1'b0;
        hold_left--;
      end else if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES - 1;
        res_ready <= 1'b0;
      end else begin
        res_ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic pts_in_t mk(logic [3:0] c, logic [7:0] id, logic [31:0] t);
    pts_in_t it;
    it.cmd     = c;
    it.task_id = id;
    it.ticks   = t;
    return it;
  endfunction

  // Draw one random command: mostly valid slots and short periods so tasks
  // come due often, with some invalid ids, unknown codes and wide values
  function automatic pts_in_t rand_cmd();
    pts_in_t     it;
    int unsigned r;
    r = $urandom_range(99);
    if      (r < 24) it.cmd = CMD_TICK;
    else if (r < 48) it.cmd = CMD_SCAN;
    else if (r < 62) it.cmd = CMD_ADD;
    else if (r < 68) it.cmd = CMD_DELETE;
    else if (r < 73) it.cmd = CMD_SUSPEND;
    else if (r < 80) it.cmd = CMD_RESUME;
    else if (r < 84) it.cmd = CMD_RESET;
    else if (r < 91) it.cmd = CMD_SLEEP;
    else if (r < 96) it.cmd = CMD_WAKEUP;
    else             it.cmd = 4'($urandom_range(15, 9));
    if ($urandom_range(99) < 88) it.task_id = 8'($urandom_range(NUM_TASKS - 1));
    else                         it.task_id = 8'($urandom_range(255, NUM_TASKS));
    r = $urandom_range(99);
    if (it.cmd == CMD_ADD) begin
      if      (r < 70) it.ticks = $urandom_range(6);
      else if (r < 85) it.ticks = $urandom_range(40, 7);
      else             it.ticks = $urandom;
    end else if (it.cmd == CMD_SLEEP) begin
      if      (r < 10) it.ticks = '0;
      else if (r < 80) it.ticks = $urandom_range(8, 1);
      else             it.ticks = $urandom;
    end else begin
      it.ticks = $urandom;
    end
    return it;
  endfunction

  // Offer one item; idle first at random, then hold it until accepted
  task automatic send_item(input pts_in_t it);
    if ($urandom_range(99) < snd_idle) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < snd_idle) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_data  <= it;
    do @(posedge clk); while (!cmd_ready);
  endtask

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++) send_item(rand_cmd());
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb        = new();
    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd_data  = '0;
    res_ready = 1'b0;
    hold_req  = 0;
    snd_idle  = 26;
    rcv_idle  = 85;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, rejected commands, fill to full, overflow add
    send_item(mk(CMD_SCAN, 8'd0, 32'd0));            // nothing due
    send_item(mk(CMD_SLEEP, 8'd1, 32'd0));           // zero sleep beats unused
    send_item(mk(CMD_WAKEUP, 8'd1, 32'd5));          // slot not in use
    send_item(mk(CMD_ADD, 8'd255, 32'hFFFF_FFFF));   // id out of range
    send_item(mk(4'd15, 8'd0, 32'hFFFF_FFFF));       // unknown command
    for (int s = 0; s < NUM_TASKS; s++) begin
      if (s == 0)                  send_item(mk(CMD_ADD, 8'(s), 32'd0));
      else if (s == NUM_TASKS - 1) send_item(mk(CMD_ADD, 8'(s), 32'hFFFF_FFFF));
      else                         send_item(mk(CMD_ADD, 8'(s), $urandom_range(3)));
    end
    send_item(mk(CMD_ADD, 8'd5, 32'd1));             // full, slot already used
    send_item(mk(CMD_TICK, 8'd0, 32'd0));
    send_item(mk(CMD_SCAN, 8'd0, 32'd0));            // many tasks due at once
    send_item(mk(CMD_DELETE, 8'(NUM_TASKS - 1), 32'd0));

    // Random, slow receiver
    send_random(RAND_A);

    // Random, slow sender
    snd_idle = 85;
    rcv_idle = 26;
    send_random(RAND_B);

    // Random, no idling; hold the receiver off so the block backs up
    snd_idle = 0;
    rcv_idle = 0;
    hold_req++;
    send_random(RAND_C);
    cmd_valid <= 1'b0;

    // Drain owed results, then let any trailing activity show up
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d commands: %0d scans emitting %0d task runs",
             sb.cmds_seen, sb.scans_seen, sb.runs_seen);
    $display("statuses ok/invalid/unused/full: %0d/%0d/%0d/%0d",
             sb.sts_cnt[STS_OK], sb.sts_cnt[STS_INVALID],
             sb.sts_cnt[STS_UNUSED], sb.sts_cnt[STS_FULL]);
    if (sb.pending() != 0) begin
      $display("%0t: owed result items expected 0 actual %0d", $time, sb.pending());
    end
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
